>>> rtl/dpct_pkg.sv
// shared constants, types and sine table function for the dq park/clarke transform
package dpct_pkg;

    // default sizing handed to the top level
    localparam int ANGLE_STEPS_DEF  = 360;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // fixed field and table widths
    localparam int ANGLE_W   = 9;
    localparam int SINE_W    = 16;
    localparam int FRAC_BITS = 15;
    localparam int RND_HALF  = 1 << (FRAC_BITS - 1);

    // op codes
    localparam logic OP_FORWARD = 1'b0;
    localparam logic OP_INVERSE = 1'b1;

    // q1.15 transform coefficients
    localparam logic signed [SINE_W-1:0] K_0408 = 16'sd13369;
    localparam logic signed [SINE_W-1:0] K_0707 = 16'sd23167;
    localparam logic signed [SINE_W-1:0] K_0816 = 16'sd26739;

    // pi in q2.30 and the taylor series divisors (2n)(2n+1)
    localparam longint unsigned PI_Q30      = 64'd3373259426;
    localparam longint unsigned HALF_PI_Q30 = PI_Q30 / 2;
    localparam int SERIES_TERMS = 10;
    localparam longint unsigned SERIES_DIV [SERIES_TERMS+1] = '{
        64'd1, 64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
        64'd156, 64'd210, 64'd272, 64'd342, 64'd420
    };

    // per-stage load enables of the pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
        logic s7;
    } stage_en_t;

    // sine in q1.15 of an angle given in q2.30 radians, folded to the first quadrant
    function automatic logic signed [SINE_W-1:0] sine_q15(input longint unsigned x_in);
        longint unsigned x;
        longint unsigned sum;
        longint unsigned term;
        longint unsigned q;
        logic            neg;
        logic [SINE_W-1:0] res;
        x   = x_in;
        neg = 1'b0;
        if (x >= PI_Q30)
        begin
            neg = 1'b1;
            x   = x - PI_Q30;
        end
        if (x > HALF_PI_Q30)
        begin
            x = PI_Q30 - x;
        end
        sum  = x;
        term = x;
        for (int n = 1; n <= SERIES_TERMS; n++)
        begin
            term = (((term * x) >> 30) * x) >> 30;
            term = term / SERIES_DIV[n];
            if ((n & 1) != 0)
                sum = sum - term;
            else
                sum = sum + term;
        end
        q = (sum + 64'd16384) >> 15;
        if (q > 64'd32768)
            q = 64'd32768;
        if (neg)
            res = SINE_W'(64'd0 - q);
        else if (q > 64'd32767)
            res = 16'h7fff;
        else
            res = SINE_W'(q);
        return res;
    endfunction

endpackage

>>> rtl/dq_park_clarke_transform.sv
// top level of the power-invariant clarke/park (dq) transform pipeline
//
// Input channel (in_valid / in_stall) takes one word per cycle while in_stall is low: op, angle_deg
// and the signed operands. op forward turns phase_a/b/c_in into direct_out
// and quad_out; op inverse turns direct_in and quad_in into phase_a/b/c_out.
// Unused outputs of a word read zero; saturated flags any clipped output.
// The angle is reduced modulo ANGLE_STEPS; cosine is read a quarter turn on.
// Seven register stages lie between the input channel and the output channel
// (out_valid / out_stall). Throughput is one word per clock while out_stall
// is low, set by the fully pipelined multipliers and the two-port registered
// sine rom.
// When the receiver stalls, the output word holds and bubbles in the pipe
// still close up; in_stall rises only once every stage holds a word.
// rst_n clears all valid bits asynchronously; no words are in flight after
// reset and the block is ready at once (the rom is constant, no fill pass).
module dq_park_clarke_transform #(
    parameter int ANGLE_STEPS  = dpct_pkg::ANGLE_STEPS_DEF,
    parameter int SAMPLE_WIDTH = dpct_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                op,
    input  logic [dpct_pkg::ANGLE_W-1:0]        angle_deg,
    input  logic signed [SAMPLE_WIDTH-1:0]      phase_a_in,
    input  logic signed [SAMPLE_WIDTH-1:0]      phase_b_in,
    input  logic signed [SAMPLE_WIDTH-1:0]      phase_c_in,
    input  logic signed [SAMPLE_WIDTH-1:0]      direct_in,
    input  logic signed [SAMPLE_WIDTH-1:0]      quad_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [SAMPLE_WIDTH+1:0]      direct_out,
    output logic signed [SAMPLE_WIDTH+1:0]      quad_out,
    output logic signed [SAMPLE_WIDTH+1:0]      phase_a_out,
    output logic signed [SAMPLE_WIDTH+1:0]      phase_b_out,
    output logic signed [SAMPLE_WIDTH+1:0]      phase_c_out,
    output logic                                saturated
);

    localparam int OUT_W  = SAMPLE_WIDTH + 2;
    localparam int AB_W   = SAMPLE_WIDTH + 1;
    localparam int IAB_W  = SAMPLE_WIDTH + 2;
    localparam int PW     = SAMPLE_WIDTH + 18;
    localparam int RW     = OUT_W + 1;
    localparam int AIDX_W = $clog2(ANGLE_STEPS);
    localparam int STAGES = 7;

    dpct_pkg::stage_en_t en;
    logic [STAGES-1:0]   valid_reg;

    // op travels with the word through stages 1 to 6
    logic op1_reg, op2_reg, op3_reg, op4_reg, op5_reg, op6_reg;

    // stage 1: clarke sums and inverse operands
    logic signed [OUT_W-1:0]        sa_next;
    logic signed [AB_W-1:0]         sb_next;
    logic signed [OUT_W-1:0]        sa1_reg;
    logic signed [AB_W-1:0]         sb1_reg;
    logic signed [SAMPLE_WIDTH-1:0] d1_reg;
    logic signed [SAMPLE_WIDTH-1:0] q1_reg;

    // stage 2: clarke alpha/beta
    logic signed [PW-1:0]           pa_clk;
    logic signed [PW-1:0]           pb_clk;
    logic signed [AB_W-1:0]         alpha_next;
    logic signed [AB_W-1:0]         beta_next;
    logic signed [AB_W-1:0]         alpha2_reg;
    logic signed [AB_W-1:0]         beta2_reg;
    logic signed [SAMPLE_WIDTH-1:0] d2_reg;
    logic signed [SAMPLE_WIDTH-1:0] q2_reg;

    // stage 3: rotator operands
    logic signed [AB_W-1:0]         x_next;
    logic signed [AB_W-1:0]         y_next;
    logic signed [AB_W-1:0]         x3_reg;
    logic signed [AB_W-1:0]         y3_reg;

    // table interface
    logic [AIDX_W-1:0]                    sin_idx;
    logic [AIDX_W-1:0]                    cos_idx;
    logic signed [dpct_pkg::SINE_W-1:0]   sin_val;
    logic signed [dpct_pkg::SINE_W-1:0]   cos_val;

    // stage 5 results from the rotator
    logic signed [RW-1:0]           rot_a;
    logic signed [RW-1:0]           rot_b;

    // stage 6: forward saturation and inverse clarke products
    logic [OUT_W:0]                 sat_d;
    logic [OUT_W:0]                 sat_q;
    logic signed [IAB_W-1:0]        alpha_i;
    logic signed [IAB_W-1:0]        beta_i;
    logic signed [PW-1:0]           pa816_next;
    logic signed [PW-1:0]           pa408_next;
    logic signed [PW-1:0]           pb707_next;
    logic signed [OUT_W-1:0]        dir6_reg;
    logic signed [OUT_W-1:0]        quad6_reg;
    logic                           clipf6_reg;
    logic signed [PW-1:0]           pa816_reg;
    logic signed [PW-1:0]           pa408_reg;
    logic signed [PW-1:0]           pb707_reg;

    // stage 7: inverse sums and the output word
    logic signed [PW-1:0]           sum_pa;
    logic signed [PW-1:0]           sum_pb;
    logic signed [PW-1:0]           sum_pc;
    logic [OUT_W:0]                 sat_a;
    logic [OUT_W:0]                 sat_b;
    logic [OUT_W:0]                 sat_c;
    logic signed [OUT_W-1:0]        dir_out_next;
    logic signed [OUT_W-1:0]        quad_out_next;
    logic signed [OUT_W-1:0]        pha_out_next;
    logic signed [OUT_W-1:0]        phb_out_next;
    logic signed [OUT_W-1:0]        phc_out_next;
    logic                           sat_out_next;
    logic signed [OUT_W-1:0]        dir_out_reg;
    logic signed [OUT_W-1:0]        quad_out_reg;
    logic signed [OUT_W-1:0]        pha_out_reg;
    logic signed [OUT_W-1:0]        phb_out_reg;
    logic signed [OUT_W-1:0]        phc_out_reg;
    logic                           sat_out_reg;

    // clip a rounded value to the output range; top bit is the clip flag
    function automatic logic [OUT_W:0] saturate(input logic signed [RW-1:0] v);
        logic [OUT_W:0] res;
        if (v[RW-1] != v[RW-2])
            res = {1'b1, v[RW-1], {(OUT_W-1){~v[RW-1]}}};
        else
            res = {1'b0, v[OUT_W-1:0]};
        return res;
    endfunction

    // stage enables: a stage loads when empty or when the next one moves
    always_comb
    begin
        en.s7 = !valid_reg[6] || !out_stall;
        en.s6 = !valid_reg[5] || en.s7;
        en.s5 = !valid_reg[4] || en.s6;
        en.s4 = !valid_reg[3] || en.s5;
        en.s3 = !valid_reg[2] || en.s4;
        en.s2 = !valid_reg[1] || en.s3;
        en.s1 = !valid_reg[0] || en.s2;
    end

    assign in_stall = !en.s1;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en.s1) valid_reg[0] <= in_valid;
            if (en.s2) valid_reg[1] <= valid_reg[0];
            if (en.s3) valid_reg[2] <= valid_reg[1];
            if (en.s4) valid_reg[3] <= valid_reg[2];
            if (en.s5) valid_reg[4] <= valid_reg[3];
            if (en.s6) valid_reg[5] <= valid_reg[4];
            if (en.s7) valid_reg[6] <= valid_reg[5];
        end
    end

    // op pipeline
    always_ff @(posedge clk)
    begin
        if (en.s1) op1_reg <= op;
        if (en.s2) op2_reg <= op1_reg;
        if (en.s3) op3_reg <= op2_reg;
        if (en.s4) op4_reg <= op3_reg;
        if (en.s5) op5_reg <= op4_reg;
        if (en.s6) op6_reg <= op5_reg;
    end

    // clarke sums 2a-b-c and b-c
    assign sa_next = OUT_W'(phase_a_in) + OUT_W'(phase_a_in)
                   - OUT_W'(phase_b_in) - OUT_W'(phase_c_in);
    assign sb_next = AB_W'(phase_b_in) - AB_W'(phase_c_in);

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            sa1_reg <= sa_next;
            sb1_reg <= sb_next;
            d1_reg  <= direct_in;
            q1_reg  <= quad_in;
        end
    end

    // clarke coefficient products, rounded
    always_comb
    begin
        pa_clk     = PW'(sa1_reg) * PW'(dpct_pkg::K_0408) + PW'(dpct_pkg::RND_HALF);
        pb_clk     = PW'(sb1_reg) * PW'(dpct_pkg::K_0707) + PW'(dpct_pkg::RND_HALF);
        alpha_next = AB_W'(pa_clk >>> dpct_pkg::FRAC_BITS);
        beta_next  = AB_W'(pb_clk >>> dpct_pkg::FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            alpha2_reg <= alpha_next;
            beta2_reg  <= beta_next;
            d2_reg     <= d1_reg;
            q2_reg     <= q1_reg;
        end
    end

    // rotator input select by op
    always_comb
    begin
        if (op2_reg == dpct_pkg::OP_INVERSE)
        begin
            x_next = AB_W'(d2_reg);
            y_next = AB_W'(q2_reg);
        end
        else
        begin
            x_next = alpha2_reg;
            y_next = beta2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            x3_reg <= x_next;
            y3_reg <= y_next;
        end
    end

    dpct_angle_index #(
        .ANGLE_STEPS (ANGLE_STEPS)
    ) u_angle (
        .clk       (clk),
        .en        (en),
        .angle_deg (angle_deg),
        .sin_idx   (sin_idx),
        .cos_idx   (cos_idx)
    );

    dpct_sine_rom #(
        .ANGLE_STEPS (ANGLE_STEPS)
    ) u_rom (
        .clk     (clk),
        .en      (en),
        .sin_idx (sin_idx),
        .cos_idx (cos_idx),
        .sin_val (sin_val),
        .cos_val (cos_val)
    );

    // the rotator's products are formed from stage 3 registers
    dpct_rotator #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_rot (
        .clk     (clk),
        .en      (en),
        .inverse (op3_reg),
        .x_val   (x3_reg),
        .y_val   (y3_reg),
        .sin_val (sin_val),
        .cos_val (cos_val),
        .rot_a   (rot_a),
        .rot_b   (rot_b)
    );

    // forward clip and inverse clarke products
    always_comb
    begin
        sat_d      = saturate(rot_a);
        sat_q      = saturate(rot_b);
        alpha_i    = IAB_W'(rot_a);
        beta_i     = IAB_W'(rot_b);
        pa816_next = PW'(alpha_i) * PW'(dpct_pkg::K_0816);
        pa408_next = PW'(alpha_i) * PW'(dpct_pkg::K_0408);
        pb707_next = PW'(beta_i) * PW'(dpct_pkg::K_0707);
    end

    always_ff @(posedge clk)
    begin
        if (en.s6)
        begin
            dir6_reg   <= sat_d[OUT_W-1:0];
            quad6_reg  <= sat_q[OUT_W-1:0];
            clipf6_reg <= sat_d[OUT_W] | sat_q[OUT_W];
            pa816_reg  <= pa816_next;
            pa408_reg  <= pa408_next;
            pb707_reg  <= pb707_next;
        end
    end

    // inverse phase sums, rounding, clip and output word select
    always_comb
    begin
        sum_pa = pa816_reg + PW'(dpct_pkg::RND_HALF);
        sum_pb = pb707_reg - pa408_reg + PW'(dpct_pkg::RND_HALF);
        sum_pc = PW'(0) - pa408_reg - pb707_reg + PW'(dpct_pkg::RND_HALF);
        sat_a  = saturate(RW'(sum_pa >>> dpct_pkg::FRAC_BITS));
        sat_b  = saturate(RW'(sum_pb >>> dpct_pkg::FRAC_BITS));
        sat_c  = saturate(RW'(sum_pc >>> dpct_pkg::FRAC_BITS));
        if (op6_reg == dpct_pkg::OP_INVERSE)
        begin
            dir_out_next  = '0;
            quad_out_next = '0;
            pha_out_next  = sat_a[OUT_W-1:0];
            phb_out_next  = sat_b[OUT_W-1:0];
            phc_out_next  = sat_c[OUT_W-1:0];
            sat_out_next  = sat_a[OUT_W] | sat_b[OUT_W] | sat_c[OUT_W];
        end
        else
        begin
            dir_out_next  = dir6_reg;
            quad_out_next = quad6_reg;
            pha_out_next  = '0;
            phb_out_next  = '0;
            phc_out_next  = '0;
            sat_out_next  = clipf6_reg;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en.s7)
        begin
            dir_out_reg  <= dir_out_next;
            quad_out_reg <= quad_out_next;
            pha_out_reg  <= pha_out_next;
            phb_out_reg  <= phb_out_next;
            phc_out_reg  <= phc_out_next;
            sat_out_reg  <= sat_out_next;
        end
    end

    assign out_valid   = valid_reg[6];
    assign direct_out  = dir_out_reg;
    assign quad_out    = quad_out_reg;
    assign phase_a_out = pha_out_reg;
    assign phase_b_out = phb_out_reg;
    assign phase_c_out = phc_out_reg;
    assign saturated   = sat_out_reg;

endmodule

>>> rtl/dpct_angle_index.sv
// angle reduction modulo the table length and sine/cosine table indexes
module dpct_angle_index #(
    parameter int ANGLE_STEPS = dpct_pkg::ANGLE_STEPS_DEF
) (
    input  logic                              clk,
    input  dpct_pkg::stage_en_t               en,
    input  logic [dpct_pkg::ANGLE_W-1:0]      angle_deg,
    output logic [$clog2(ANGLE_STEPS)-1:0]    sin_idx,
    output logic [$clog2(ANGLE_STEPS)-1:0]    cos_idx
);

    localparam int AIDX_W  = $clog2(ANGLE_STEPS);
    localparam int SHIFT   = dpct_pkg::ANGLE_W + AIDX_W;
    localparam int RECIP_W = dpct_pkg::ANGLE_W + 2;
    localparam int RECIP   = ((1 << SHIFT) + ANGLE_STEPS - 1) / ANGLE_STEPS;
    localparam int PROD_W  = dpct_pkg::ANGLE_W + RECIP_W;
    localparam int TMP_W   = dpct_pkg::ANGLE_W + AIDX_W + 1;
    localparam int QUARTER = ANGLE_STEPS / 4;

    logic [dpct_pkg::ANGLE_W-1:0] quot_next;
    logic [dpct_pkg::ANGLE_W-1:0] quot_reg;
    logic [dpct_pkg::ANGLE_W-1:0] ang_reg;
    logic [TMP_W-1:0]             rem_val;
    logic [TMP_W-1:0]             cos_sum;
    logic [AIDX_W-1:0]            sin_idx_next;
    logic [AIDX_W-1:0]            cos_idx_next;
    logic [AIDX_W-1:0]            sin_idx_reg;
    logic [AIDX_W-1:0]            cos_idx_reg;

    // quotient by reciprocal multiply, exact for every 9-bit angle
    assign quot_next = dpct_pkg::ANGLE_W'(
        (PROD_W'(angle_deg) * PROD_W'(RECIP)) >> SHIFT);

    // remainder and quarter-turn offset for cosine
    always_comb
    begin
        rem_val = TMP_W'(ang_reg) - TMP_W'(quot_reg) * TMP_W'(ANGLE_STEPS);
        cos_sum = rem_val + TMP_W'(QUARTER);
        if (cos_sum >= TMP_W'(ANGLE_STEPS))
            cos_sum = cos_sum - TMP_W'(ANGLE_STEPS);
        sin_idx_next = AIDX_W'(rem_val);
        cos_idx_next = AIDX_W'(cos_sum);
    end

    // stage 1 quotient
    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            quot_reg <= quot_next;
            ang_reg  <= angle_deg;
        end
    end

    // stage 2 indexes
    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            sin_idx_reg <= sin_idx_next;
            cos_idx_reg <= cos_idx_next;
        end
    end

    assign sin_idx = sin_idx_reg;
    assign cos_idx = cos_idx_reg;

endmodule

>>> rtl/dpct_sine_rom.sv
// sine table rom with two registered read ports
module dpct_sine_rom #(
    parameter int ANGLE_STEPS = dpct_pkg::ANGLE_STEPS_DEF
) (
    input  logic                                    clk,
    input  dpct_pkg::stage_en_t                     en,
    input  logic [$clog2(ANGLE_STEPS)-1:0]          sin_idx,
    input  logic [$clog2(ANGLE_STEPS)-1:0]          cos_idx,
    output logic signed [dpct_pkg::SINE_W-1:0]      sin_val,
    output logic signed [dpct_pkg::SINE_W-1:0]      cos_val
);

    logic signed [dpct_pkg::SINE_W-1:0] rom_mem [ANGLE_STEPS];
    logic signed [dpct_pkg::SINE_W-1:0] sin_reg;
    logic signed [dpct_pkg::SINE_W-1:0] cos_reg;

    // table contents, one entry per angle step
    for (genvar k = 0; k < ANGLE_STEPS; k++)
    begin : g_entry
        localparam longint unsigned ARG_Q30 =
            (64'd2 * dpct_pkg::PI_Q30 * 64'(k)) / 64'(ANGLE_STEPS);
        assign rom_mem[k] = dpct_pkg::sine_q15(ARG_Q30);
    end

    // stage 3 registered reads
    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            sin_reg <= rom_mem[sin_idx];
            cos_reg <= rom_mem[cos_idx];
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

>>> rtl/dpct_rotator.sv
// park rotation shared by both directions: four products, then rounded sums
module dpct_rotator #(
    parameter int SAMPLE_WIDTH = dpct_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                clk,
    input  dpct_pkg::stage_en_t                 en,
    input  logic                                inverse,
    input  logic signed [SAMPLE_WIDTH:0]        x_val,
    input  logic signed [SAMPLE_WIDTH:0]        y_val,
    input  logic signed [dpct_pkg::SINE_W-1:0]  sin_val,
    input  logic signed [dpct_pkg::SINE_W-1:0]  cos_val,
    output logic signed [SAMPLE_WIDTH+2:0]      rot_a,
    output logic signed [SAMPLE_WIDTH+2:0]      rot_b
);

    localparam int SN_W = dpct_pkg::SINE_W + 1;
    localparam int PW   = SAMPLE_WIDTH + 18;
    localparam int RW   = SAMPLE_WIDTH + 3;

    logic signed [SN_W-1:0] sin_eff;
    logic signed [PW-1:0]   pcx_next;
    logic signed [PW-1:0]   psy_next;
    logic signed [PW-1:0]   pcy_next;
    logic signed [PW-1:0]   psx_next;
    logic signed [PW-1:0]   pcx_reg;
    logic signed [PW-1:0]   psy_reg;
    logic signed [PW-1:0]   pcy_reg;
    logic signed [PW-1:0]   psx_reg;
    logic signed [PW-1:0]   sum_a;
    logic signed [PW-1:0]   sum_b;
    logic signed [RW-1:0]   rot_a_next;
    logic signed [RW-1:0]   rot_b_next;
    logic signed [RW-1:0]   rot_a_reg;
    logic signed [RW-1:0]   rot_b_reg;

    // inverse rotation is the forward one with the sine negated
    always_comb
    begin
        if (inverse)
            sin_eff = SN_W'(0) - SN_W'(sin_val);
        else
            sin_eff = SN_W'(sin_val);
        pcx_next = PW'(cos_val) * PW'(x_val);
        psy_next = PW'(sin_eff) * PW'(y_val);
        pcy_next = PW'(cos_val) * PW'(y_val);
        psx_next = PW'(sin_eff) * PW'(x_val);
    end

    // stage 4 products
    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            pcx_reg <= pcx_next;
            psy_reg <= psy_next;
            pcy_reg <= pcy_next;
            psx_reg <= psx_next;
        end
    end

    // sums rounded to nearest, halves upward
    always_comb
    begin
        sum_a      = pcx_reg + psy_reg + PW'(dpct_pkg::RND_HALF);
        sum_b      = pcy_reg - psx_reg + PW'(dpct_pkg::RND_HALF);
        rot_a_next = RW'(sum_a >>> dpct_pkg::FRAC_BITS);
        rot_b_next = RW'(sum_b >>> dpct_pkg::FRAC_BITS);
    end

    // stage 5 rotated pair
    always_ff @(posedge clk)
    begin
        if (en.s5)
        begin
            rot_a_reg <= rot_a_next;
            rot_b_reg <= rot_b_next;
        end
    end

    assign rot_a = rot_a_reg;
    assign rot_b = rot_b_reg;

endmodule

>>> rtl/dpct_port_check.sv
// port-level checker for the transform block and its bind
module dpct_port_check #(
    parameter int OUT_W = dpct_pkg::SAMPLE_WIDTH_DEF + 2
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_stall,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic signed [OUT_W-1:0] direct_out,
    input logic signed [OUT_W-1:0] quad_out,
    input logic signed [OUT_W-1:0] phase_a_out,
    input logic signed [OUT_W-1:0] phase_b_out,
    input logic signed [OUT_W-1:0] phase_c_out,
    input logic                    saturated
);

    localparam logic [OUT_W-1:0] MAX_VAL = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] MIN_VAL = {1'b1, {(OUT_W-1){1'b0}}};

    // no word is shown while reset is held
    assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output word valid during reset");

    // input backpressure only comes from a full pipe behind a stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output backpressure");

    // a stalled output word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(direct_out) && $stable(quad_out)
            && $stable(phase_a_out) && $stable(phase_b_out) && $stable(phase_c_out)
            && $stable(saturated))
        else $error("stalled output word changed");

    // one side of every word is zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (direct_out == '0 && quad_out == '0)
            || (phase_a_out == '0 && phase_b_out == '0 && phase_c_out == '0))
        else $error("both forward and inverse outputs nonzero");

    // a clip flag means some output sits at a range limit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            direct_out == MAX_VAL || direct_out == MIN_VAL
            || quad_out == MAX_VAL || quad_out == MIN_VAL
            || phase_a_out == MAX_VAL || phase_a_out == MIN_VAL
            || phase_b_out == MAX_VAL || phase_b_out == MIN_VAL
            || phase_c_out == MAX_VAL || phase_c_out == MIN_VAL)
        else $error("saturated set with no output at a limit");

endmodule

bind dq_park_clarke_transform dpct_port_check #(
    .OUT_W (SAMPLE_WIDTH + 2)
) u_port_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .direct_out  (direct_out),
    .quad_out    (quad_out),
    .phase_a_out (phase_a_out),
    .phase_b_out (phase_b_out),
    .phase_c_out (phase_c_out),
    .saturated   (saturated)
);

>>> tb/tb_dq_park_clarke_transform.sv
// testbench for the dq park/clarke transform: random and directed words checked against a predictor
module tb_dq_park_clarke_transform;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int    STEPS        = 360;
    localparam int    SAMPLE_W     = 16;
    localparam int    RESULT_W     = SAMPLE_W + 2;
    localparam int    LIMIT_CYCLES = 200000;
    localparam int    HOLD_CYCLES  = 80;
    localparam int    MAX_REPORTS  = 10;
    localparam int    DRAIN_CYCLES = 20;
    localparam longint RESULT_MAX  = (64'sd1 <<< (RESULT_W - 1)) - 1;
    localparam longint RESULT_MIN  = -RESULT_MAX - 1;

    // q1.15 coefficients and pi in q2.30
    localparam longint COEF_0408 = 13369;
    localparam longint COEF_0707 = 23167;
    localparam longint COEF_0816 = 26739;
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // one input word and one result word
    typedef struct packed {
        logic                       op;
        logic [8:0]                 ang;
        logic signed [SAMPLE_W-1:0] pa;
        logic signed [SAMPLE_W-1:0] pb;
        logic signed [SAMPLE_W-1:0] pc;
        logic signed [SAMPLE_W-1:0] d;
        logic signed [SAMPLE_W-1:0] q;
    } dq_word_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] direct;
        logic signed [RESULT_W-1:0] quad;
        logic signed [RESULT_W-1:0] pha;
        logic signed [RESULT_W-1:0] phb;
        logic signed [RESULT_W-1:0] phc;
        logic                       sat;
    } dq_result_t;

    // transform predictor and in-order store of awaited result words
    class dq_scoreboard;
        int         sine_tab [STEPS];
        dq_result_t awaited_results [$];
        int         errors;

        // sine table in q1.15 from a folded taylor series in q2.30
        function new();
            longint unsigned x;
            longint unsigned sum;
            longint unsigned term;
            longint unsigned qv;
            bit              neg;
            errors = 0;
            for (int k = 0; k < STEPS; k++)
            begin
                x   = (2 * PI_Q30 * longint'(k)) / STEPS;
                neg = 1'b0;
                if (x >= PI_Q30)
                begin
                    neg = 1'b1;
                    x   = x - PI_Q30;
                end
                if (x > PI_Q30 / 2)
                    x = PI_Q30 - x;
                sum  = x;
                term = x;
                for (int n = 1; n <= 10; n++)
                begin
                    term = (((term * x) >> 30) * x) >> 30;
                    term = term / longint'((2 * n) * (2 * n + 1));
                    if ((n % 2) != 0)
                        sum = sum - term;
                    else
                        sum = sum + term;
                end
                qv = (sum + 64'd16384) >> 15;
                if (qv > 64'd32768)
                    qv = 64'd32768;
                if (neg)
                    sine_tab[k] = -int'(qv);
                else
                    sine_tab[k] = (qv > 64'd32767) ? 32767 : int'(qv);
            end
        endfunction

        // round to nearest, halves up, dropping 15 fraction bits
        function longint round_q15(longint v);
            return (v + 64'sd16384) >>> 15;
        endfunction

        // clip to the output width and flag any clipping
        function logic signed [RESULT_W-1:0] clamp_out(longint v, inout bit clip);
            if (v > RESULT_MAX)
            begin
                clip = 1'b1;
                return RESULT_MAX[RESULT_W-1:0];
            end
            if (v < RESULT_MIN)
            begin
                clip = 1'b1;
                return RESULT_MIN[RESULT_W-1:0];
            end
            return v[RESULT_W-1:0];
        endfunction

        // expected result of one word
        function dq_result_t predict_transform(dq_word_t w);
            longint     si;
            longint     co;
            longint     a;
            longint     b;
            longint     c;
            longint     d;
            longint     q;
            longint     alpha;
            longint     beta;
            int         ai;
            int         ci;
            bit         clip;
            dq_result_t r;
            ai   = int'(w.ang) % STEPS;
            ci   = (ai + STEPS / 4) % STEPS;
            si   = sine_tab[ai];
            co   = sine_tab[ci];
            clip = 1'b0;
            r    = '0;
            if (w.op == dpct_pkg::OP_FORWARD)
            begin
                a        = w.pa;
                b        = w.pb;
                c        = w.pc;
                alpha    = round_q15((2 * a - b - c) * COEF_0408);
                beta     = round_q15((b - c) * COEF_0707);
                r.direct = clamp_out(round_q15(co * alpha + si * beta), clip);
                r.quad   = clamp_out(round_q15(co * beta - si * alpha), clip);
            end
            else
            begin
                d     = w.d;
                q     = w.q;
                alpha = round_q15(co * d - si * q);
                beta  = round_q15(si * d + co * q);
                r.pha = clamp_out(round_q15(COEF_0816 * alpha), clip);
                r.phb = clamp_out(round_q15(-COEF_0408 * alpha + COEF_0707 * beta), clip);
                r.phc = clamp_out(round_q15(-COEF_0408 * alpha - COEF_0707 * beta), clip);
            end
            r.sat = clip;
            return r;
        endfunction

        function void fail_note(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("ERROR at %0t: %s", $realtime, msg);
        endfunction

        // an input word was accepted
        function void note_word(dq_word_t w);
            awaited_results.push_back(predict_transform(w));
        endfunction

        // a result word was accepted
        function void check_result(dq_result_t got);
            dq_result_t want;
            if (awaited_results.size() == 0)
            begin
                fail_note($sformatf("result word with none awaited: d=%0d q=%0d a=%0d b=%0d c=%0d",
                                    got.direct, got.quad, got.pha, got.phb, got.phc));
                return;
            end
            want = awaited_results.pop_front();
            if (got.direct !== want.direct || got.quad !== want.quad ||
                got.pha !== want.pha || got.phb !== want.phb ||
                got.phc !== want.phc || got.sat !== want.sat)
            begin
                fail_note($sformatf({"mismatch: expected d=%0d q=%0d a=%0d b=%0d c=%0d sat=%0b",
                                     " got d=%0d q=%0d a=%0d b=%0d c=%0d sat=%0b"},
                                    want.direct, want.quad, want.pha, want.phb, want.phc,
                                    want.sat, got.direct, got.quad, got.pha, got.phb,
                                    got.phc, got.sat));
            end
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic                       op;
    logic [8:0]                 angle_deg;
    logic signed [SAMPLE_W-1:0] phase_a_in;
    logic signed [SAMPLE_W-1:0] phase_b_in;
    logic signed [SAMPLE_W-1:0] phase_c_in;
    logic signed [SAMPLE_W-1:0] direct_in;
    logic signed [SAMPLE_W-1:0] quad_in;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [RESULT_W-1:0] direct_out;
    logic signed [RESULT_W-1:0] quad_out;
    logic signed [RESULT_W-1:0] phase_a_out;
    logic signed [RESULT_W-1:0] phase_b_out;
    logic signed [RESULT_W-1:0] phase_c_out;
    logic                       saturated;

    bit           hold_req = 1'b0;
    dq_scoreboard sb;

    dq_park_clarke_transform DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .angle_deg   (angle_deg),
        .phase_a_in  (phase_a_in),
        .phase_b_in  (phase_b_in),
        .phase_c_in  (phase_c_in),
        .direct_in   (direct_in),
        .quad_in     (quad_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .direct_out  (direct_out),
        .quad_out    (quad_out),
        .phase_a_out (phase_a_out),
        .phase_b_out (phase_b_out),
        .phase_c_out (phase_c_out),
        .saturated   (saturated)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // sample both channels at the rising edge
    always @(posedge clk)
    begin
        dq_word_t   w;
        dq_result_t r;
        if (rst_n && in_valid && !in_stall)
        begin
            w.op  = op;
            w.ang = angle_deg;
            w.pa  = phase_a_in;
            w.pb  = phase_b_in;
            w.pc  = phase_c_in;
            w.d   = direct_in;
            w.q   = quad_in;
            sb.note_word(w);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            r.direct = direct_out;
            r.quad   = quad_out;
            r.pha    = phase_a_out;
            r.phb    = phase_b_out;
            r.phc    = phase_c_out;
            r.sat    = saturated;
            sb.check_result(r);
        end
    end

    // operand mix: extremes, values near zero, full random
    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // word with the given operands; fields the op ignores get noise
    function automatic dq_word_t make_word(logic op_sel, int ang,
                                           logic signed [SAMPLE_W-1:0] x0,
                                           logic signed [SAMPLE_W-1:0] x1,
                                           logic signed [SAMPLE_W-1:0] x2);
        dq_word_t w;
        w.op  = op_sel;
        w.ang = 9'(ang);
        w.pa  = (op_sel == dpct_pkg::OP_FORWARD) ? x0 : rand_sample();
        w.pb  = (op_sel == dpct_pkg::OP_FORWARD) ? x1 : rand_sample();
        w.pc  = (op_sel == dpct_pkg::OP_FORWARD) ? x2 : rand_sample();
        w.d   = (op_sel == dpct_pkg::OP_INVERSE) ? x0 : rand_sample();
        w.q   = (op_sel == dpct_pkg::OP_INVERSE) ? x1 : rand_sample();
        return w;
    endfunction

    // mostly in-range angles, now and then one past a full turn
    function automatic dq_word_t random_word();
        int ang;
        ang = ($urandom_range(0, 19) == 0) ? $urandom_range(STEPS, 511) : $urandom_range(0, STEPS - 1);
        return make_word($urandom_range(0, 1) ? dpct_pkg::OP_INVERSE : dpct_pkg::OP_FORWARD,
                         ang, rand_sample(), rand_sample(), rand_sample());
    endfunction

    // present one word from a falling edge until it is taken
    task automatic send_word(dq_word_t w);
        in_valid   = 1'b1;
        op         = w.op;
        angle_deg  = w.ang;
        phase_a_in = w.pa;
        phase_b_in = w.pb;
        phase_c_in = w.pc;
        direct_in  = w.d;
        quad_in    = w.q;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic pause_sender(int n);
        in_valid = 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // sender stays idle until every awaited word has come back
    task automatic wait_drained();
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // bursts of random length with random gaps, some back to back
    task automatic random_bursts(int count);
        int done;
        int len;
        done = 0;
        while (done < count)
        begin
            len = $urandom_range(1, 32);
            for (int i = 0; i < len && done < count; i++)
            begin
                send_word(random_word());
                done++;
            end
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 6));
        end
    endtask

    // receiver stall pattern, with a long hold-off on request
    initial
    begin
        int mode;
        int left;
        out_stall = 1'b0;
        mode      = 0;
        left      = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(50, 300);
                end
                left--;
                case (mode)
                    0:       out_stall = 1'b0;
                    1:       out_stall = ($urandom_range(0, 3) == 0);
                    2:       out_stall = ($urandom_range(0, 3) != 0);
                    default: out_stall = ((left % 7) < 3);
                endcase
            end
        end
    end

    // run limit
    initial
    begin
        int cycle_cnt;
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // stimulus
    initial
    begin
        dq_word_t directed [$];
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        op         = dpct_pkg::OP_FORWARD;
        angle_deg  = '0;
        phase_a_in = '0;
        phase_b_in = '0;
        phase_c_in = '0;
        direct_in  = '0;
        quad_in    = '0;
        sb         = new();
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // forward: zeros, extremes, zero-sequence input, quadrant angles
        directed.push_back(make_word(dpct_pkg::OP_FORWARD, 0, 16'sd0, 16'sd0, 16'sd0));
        directed.push_back(make_word(dpct_pkg::OP_FORWARD, 0, 16'sh7fff, 16'sh8000, 16'sh8000));
        directed.push_back(make_word(dpct_pkg::OP_FORWARD, 90, 16'sh8000, 16'sh7fff, 16'sh7fff));
        directed.push_back(make_word(dpct_pkg::OP_FORWARD, 180, 16'sh7fff, 16'sh7fff, 16'sh7fff));
        directed.push_back(make_word(dpct_pkg::OP_FORWARD, 270, -16'sd1, 16'sh7fff, 16'sh8000));
        directed.push_back(make_word(dpct_pkg::OP_FORWARD, 300, 16'sd1, 16'sh8000, 16'sh7fff));
        directed.push_back(make_word(dpct_pkg::OP_FORWARD, 359, 16'sh8000, 16'sh8000, 16'sh8000));
        directed.push_back(make_word(dpct_pkg::OP_FORWARD, 45, 16'sd1234, -16'sd4321, 16'sd77));
        // angles past a full turn wrap
        directed.push_back(make_word(dpct_pkg::OP_FORWARD, 360, 16'sh7fff, 16'sd0, 16'sh8000));
        directed.push_back(make_word(dpct_pkg::OP_FORWARD, 450, 16'sh7fff, 16'sd0, 16'sh8000));
        directed.push_back(make_word(dpct_pkg::OP_FORWARD, 511, 16'sh7fff, 16'sh8000, 16'sd0));
        // inverse: zeros, extremes, quadrant angles, wrap
        directed.push_back(make_word(dpct_pkg::OP_INVERSE, 1, 16'sd0, 16'sd0, 16'sd0));
        directed.push_back(make_word(dpct_pkg::OP_INVERSE, 0, 16'sh7fff, 16'sh8000, 16'sd0));
        directed.push_back(make_word(dpct_pkg::OP_INVERSE, 90, 16'sh8000, 16'sh7fff, 16'sd0));
        directed.push_back(make_word(dpct_pkg::OP_INVERSE, 180, 16'sh8000, 16'sh8000, 16'sd0));
        directed.push_back(make_word(dpct_pkg::OP_INVERSE, 270, 16'sh7fff, 16'sh7fff, 16'sd0));
        directed.push_back(make_word(dpct_pkg::OP_INVERSE, 359, -16'sd1, 16'sd1, 16'sd0));
        directed.push_back(make_word(dpct_pkg::OP_INVERSE, 360, 16'sh7fff, 16'sh7fff, 16'sd0));
        directed.push_back(make_word(dpct_pkg::OP_INVERSE, 511, 16'sh8000, 16'sh7fff, 16'sd0));
        directed.push_back(make_word(dpct_pkg::OP_INVERSE, 400, 16'sd2000, -16'sd3000, 16'sd0));
        foreach (directed[i])
            send_word(directed[i]);
        wait_drained();

        // receiver holds off while words keep coming, so the pipe backs up
        hold_req = 1'b1;
        repeat (48) send_word(random_word());
        random_bursts(700);
        wait_drained();
        hold_req = 1'b1;
        random_bursts(702);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
rtl/dpct_pkg.sv
rtl/dpct_angle_index.sv
rtl/dpct_sine_rom.sv
rtl/dpct_rotator.sv
rtl/dq_park_clarke_transform.sv
rtl/dpct_port_check.sv
tb/tb_dq_park_clarke_transform.sv
